// ----- rtl/core/dpa_pkg.sv -----
`timescale 1ns / 1ps

package dpa_pkg;

  // Data-processing opcodes, instr[24:21]
  typedef enum logic [3:0] {
    OP_AND = 4'h0,
    OP_EOR = 4'h1,
    OP_SUB = 4'h2,
    OP_RSB = 4'h3,
    OP_ADD = 4'h4,
    OP_ADC = 4'h5,
    OP_SBC = 4'h6,
    OP_RSC = 4'h7,
    OP_TST = 4'h8,
    OP_TEQ = 4'h9,
    OP_CMP = 4'hA,
    OP_CMN = 4'hB,
    OP_ORR = 4'hC,
    OP_MOV = 4'hD,
    OP_BIC = 4'hE,
    OP_MVN = 4'hF
  } alu_op_e;

  // Shift type field, instr[6:5]
  localparam logic [1:0] ShTypeLsl = 2'd0;
  localparam logic [1:0] ShTypeLsr = 2'd1;
  localparam logic [1:0] ShTypeAsr = 2'd2;
  localparam logic [1:0] ShTypeRor = 2'd3;

  // Normalized shift operation handed to the barrel shifter
  typedef enum logic [2:0] {
    SH_LSL,
    SH_LSR,
    SH_ASR,
    SH_ROR,
    SH_RRX
  } shift_kind_e;

  localparam int unsigned DataW = 32;
  localparam int unsigned AmtW  = 6;

  // Amount 32 is a full shift; 33 clears value and carry for LSL/LSR
  localparam logic [AmtW-1:0] AmtZero = 6'd0;
  localparam logic [AmtW-1:0] AmtFull = 6'd32;
  localparam logic [AmtW-1:0] AmtOver = 6'd33;

  localparam logic [3:0] PcReg = 4'd15;

  typedef struct packed {
    shift_kind_e       kind;
    logic [AmtW-1:0]   amount;
    logic [DataW-1:0]  data;
  } shift_req_t;

  typedef struct packed {
    alu_op_e     opcode;
    logic [3:0]  rd;
    logic        write_result;
    logic        flags_update;
    logic        restore_psr;
    logic        illegal_mode;
    logic [2:0]  cycles;
    logic        carry_in;
    logic        overflow_in;
  } ctrl_t;

endpackage

// ----- rtl/core/arm_data_processing_alu.sv -----
`timescale 1ns / 1ps

// ARM data-processing execute unit: barrel shifter plus 16-operation ALU.
// Four register stages (operand-2 decode, barrel shift, add/logic, flag
// generation into the output register) take one transaction per clock while
// the output drains, so the sustained rate is one instruction per cycle.
// Decode captures at the accepting edge; the shifter, ALU and output registers
// follow, and out_valid_o comes from the last. Each stage holds its own valid
// bit and stalls only when its successor is full, so out_ready_i low lets the
// pipeline fill up before in_ready_o drops. The cycles_o field is the
// architectural cost of the instruction, not the latency of this unit.
module arm_data_processing_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] instr_i,
  input  logic [31:0] rn_value_i,
  input  logic [31:0] rm_value_i,
  input  logic [31:0] rs_value_i,
  input  logic        carry_in_i,
  input  logic        overflow_in_i,
  input  logic        user_mode_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_o,
  output logic [3:0]  dest_reg_o,
  output logic        write_result_o,
  output logic        flags_update_o,
  output logic        flag_n_o,
  output logic        flag_z_o,
  output logic        flag_c_o,
  output logic        flag_v_o,
  output logic        restore_psr_o,
  output logic        illegal_mode_o,
  output logic [2:0]  cycles_o
);

  logic                        dec_valid, dec_ready;
  dpa_pkg::shift_req_t         dec_shift;
  logic [dpa_pkg::DataW-1:0]   dec_rn;
  dpa_pkg::ctrl_t              dec_ctrl;

  logic                        sh_valid, sh_ready;
  logic [dpa_pkg::DataW-1:0]   sh_operand;
  logic                        sh_carry;
  logic [dpa_pkg::DataW-1:0]   sh_rn;
  dpa_pkg::ctrl_t              sh_ctrl;

  logic                        alu_valid, alu_ready;
  logic [dpa_pkg::DataW-1:0]   alu_result;
  logic                        alu_carry;
  logic                        alu_ovf;
  dpa_pkg::ctrl_t              alu_ctrl;

  logic                        out_valid_q;
  logic [dpa_pkg::DataW-1:0]   result_q;
  logic                        flag_n_q, flag_z_q, flag_c_q, flag_v_q;
  dpa_pkg::ctrl_t              ctrl_q;

  // Stage 1: operand-2 decode and control
  dpa_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_valid_i),
    .ready_o       (in_ready_o),
    .instr_i       (instr_i),
    .rn_value_i    (rn_value_i),
    .rm_value_i    (rm_value_i),
    .rs_value_i    (rs_value_i),
    .carry_in_i    (carry_in_i),
    .overflow_in_i (overflow_in_i),
    .user_mode_i   (user_mode_i),
    .valid_o       (dec_valid),
    .ready_i       (dec_ready),
    .shift_o       (dec_shift),
    .rn_o          (dec_rn),
    .ctrl_o        (dec_ctrl)
  );

  // Stage 2: barrel shifter
  dpa_shifter u_shifter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (dec_valid),
    .ready_o       (dec_ready),
    .shift_i       (dec_shift),
    .rn_i          (dec_rn),
    .ctrl_i        (dec_ctrl),
    .valid_o       (sh_valid),
    .ready_i       (sh_ready),
    .operand_o     (sh_operand),
    .shift_carry_o (sh_carry),
    .rn_o          (sh_rn),
    .ctrl_o        (sh_ctrl)
  );

  // Stage 3: adder and logic unit
  dpa_alu u_alu (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (sh_valid),
    .ready_o       (sh_ready),
    .rn_i          (sh_rn),
    .operand_i     (sh_operand),
    .shift_carry_i (sh_carry),
    .ctrl_i        (sh_ctrl),
    .valid_o       (alu_valid),
    .ready_i       (alu_ready),
    .result_o      (alu_result),
    .carry_o       (alu_carry),
    .overflow_o    (alu_ovf),
    .ctrl_o        (alu_ctrl)
  );

  // Stage 4: N/Z generation into the output register
  assign alu_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (alu_ready) begin
      out_valid_q <= alu_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (alu_ready && alu_valid) begin
      result_q <= alu_result;
      flag_n_q <= alu_result[dpa_pkg::DataW-1];
      flag_z_q <= (alu_result == '0);
      flag_c_q <= alu_carry;
      flag_v_q <= alu_ovf;
      ctrl_q   <= alu_ctrl;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_o       = result_q;
  assign dest_reg_o     = ctrl_q.rd;
  assign write_result_o = ctrl_q.write_result;
  assign flags_update_o = ctrl_q.flags_update;
  assign flag_n_o       = flag_n_q;
  assign flag_z_o       = flag_z_q;
  assign flag_c_o       = flag_c_q;
  assign flag_v_o       = flag_v_q;
  assign restore_psr_o  = ctrl_q.restore_psr;
  assign illegal_mode_o = ctrl_q.illegal_mode;
  assign cycles_o       = ctrl_q.cycles;

`ifndef SYNTHESIS
  // An illegal PSR write never writes back or updates flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && illegal_mode_o |-> !write_result_o && !flags_update_o)
    else $error("illegal mode transaction writes result or flags");

  // Restore and illegal are exclusive and only happen with Rd = PC
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (restore_psr_o || illegal_mode_o) |->
      !(restore_psr_o && illegal_mode_o) && dest_reg_o == dpa_pkg::PcReg)
    else $error("PSR restore/illegal decode mismatch");

  // PC destination adds two to the cost field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cycles_o >= 3'd3) == (dest_reg_o == dpa_pkg::PcReg))
    else $error("cycle cost does not match destination");

  // Cost is always in 1..4
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cycles_o >= 3'd1 && cycles_o <= 3'd4)
    else $error("cycle cost out of range");

  // Zero and negative flags follow the result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> flag_z_o == (result_o == '0) && flag_n_o == result_o[31])
    else $error("N/Z flags inconsistent with result");
`endif

endmodule

// ----- rtl/core/dpa_decode.sv -----
`timescale 1ns / 1ps

module dpa_decode (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [31:0]                     instr_i,
  input  logic [dpa_pkg::DataW-1:0]       rn_value_i,
  input  logic [dpa_pkg::DataW-1:0]       rm_value_i,
  input  logic [dpa_pkg::DataW-1:0]       rs_value_i,
  input  logic                            carry_in_i,
  input  logic                            overflow_in_i,
  input  logic                            user_mode_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output dpa_pkg::shift_req_t             shift_o,
  output logic [dpa_pkg::DataW-1:0]       rn_o,
  output dpa_pkg::ctrl_t                  ctrl_o
);

  logic                        valid_q;
  dpa_pkg::shift_req_t         shift_d, shift_q;
  dpa_pkg::ctrl_t              ctrl_d, ctrl_q;
  logic [dpa_pkg::DataW-1:0]   rn_q;

  logic        imm_mode;
  logic        reg_shift;
  logic [1:0]  sh_type;
  logic [4:0]  imm_amt;
  logic [7:0]  rs_amt;
  logic        is_test;
  logic        pc_dest;
  logic        s_bit;

  assign imm_mode  = instr_i[25];
  assign reg_shift = !instr_i[25] && instr_i[4];
  assign sh_type   = instr_i[6:5];
  assign imm_amt   = instr_i[11:7];
  assign rs_amt    = rs_value_i[7:0];

  // Operand 2 decode: fold every encoding into kind + amount
  always_comb begin
    shift_d.kind   = dpa_pkg::SH_LSL;
    shift_d.amount = dpa_pkg::AmtZero;
    shift_d.data   = rm_value_i;
    if (imm_mode) begin
      shift_d.kind   = dpa_pkg::SH_ROR;
      shift_d.data   = {24'd0, instr_i[7:0]};
      shift_d.amount = {1'b0, instr_i[11:8], 1'b0};
    end else if (reg_shift) begin
      if (rs_amt != 8'd0) begin
        case (sh_type)
          dpa_pkg::ShTypeLsl: begin
            shift_d.kind   = dpa_pkg::SH_LSL;
            shift_d.amount = (rs_amt > 8'd32) ? dpa_pkg::AmtOver : rs_amt[5:0];
          end
          dpa_pkg::ShTypeLsr: begin
            shift_d.kind   = dpa_pkg::SH_LSR;
            shift_d.amount = (rs_amt > 8'd32) ? dpa_pkg::AmtOver : rs_amt[5:0];
          end
          dpa_pkg::ShTypeAsr: begin
            shift_d.kind   = dpa_pkg::SH_ASR;
            shift_d.amount = (rs_amt >= 8'd32) ? dpa_pkg::AmtFull : rs_amt[5:0];
          end
          default: begin
            // nonzero multiple of 32 rotates by nothing but still takes carry from bit 31
            shift_d.kind   = dpa_pkg::SH_ROR;
            shift_d.amount = (rs_amt[4:0] == 5'd0) ? dpa_pkg::AmtFull
                                                   : {1'b0, rs_amt[4:0]};
          end
        endcase
      end
    end else begin
      case (sh_type)
        dpa_pkg::ShTypeLsl: begin
          shift_d.kind   = dpa_pkg::SH_LSL;
          shift_d.amount = {1'b0, imm_amt};
        end
        dpa_pkg::ShTypeLsr: begin
          shift_d.kind   = dpa_pkg::SH_LSR;
          shift_d.amount = (imm_amt == 5'd0) ? dpa_pkg::AmtFull : {1'b0, imm_amt};
        end
        dpa_pkg::ShTypeAsr: begin
          shift_d.kind   = dpa_pkg::SH_ASR;
          shift_d.amount = (imm_amt == 5'd0) ? dpa_pkg::AmtFull : {1'b0, imm_amt};
        end
        default: begin
          // ROR #0 encodes RRX
          shift_d.kind   = (imm_amt == 5'd0) ? dpa_pkg::SH_RRX : dpa_pkg::SH_ROR;
          shift_d.amount = {1'b0, imm_amt};
        end
      endcase
    end
  end

  // Write-back and PSR control
  assign s_bit   = instr_i[20];
  assign pc_dest = (instr_i[15:12] == dpa_pkg::PcReg);

  always_comb begin
    ctrl_d.opcode = dpa_pkg::alu_op_e'(instr_i[24:21]);
    is_test       = ctrl_d.opcode inside {dpa_pkg::OP_TST, dpa_pkg::OP_TEQ,
                                          dpa_pkg::OP_CMP, dpa_pkg::OP_CMN};
    ctrl_d.rd           = instr_i[15:12];
    ctrl_d.restore_psr  = s_bit && pc_dest && !user_mode_i;
    ctrl_d.illegal_mode = s_bit && pc_dest && user_mode_i;
    ctrl_d.flags_update = s_bit && !pc_dest;
    ctrl_d.write_result = !is_test && !ctrl_d.illegal_mode;
    ctrl_d.cycles       = 3'd1 + {2'b00, reg_shift} + (pc_dest ? 3'd2 : 3'd0);
    ctrl_d.carry_in     = carry_in_i;
    ctrl_d.overflow_in  = overflow_in_i;
  end

  assign ready_o = !valid_q || ready_i;

  // Stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      shift_q <= shift_d;
      ctrl_q  <= ctrl_d;
      rn_q    <= rn_value_i;
    end
  end

  assign valid_o = valid_q;
  assign shift_o = shift_q;
  assign ctrl_o  = ctrl_q;
  assign rn_o    = rn_q;

endmodule

// ----- rtl/core/dpa_shifter.sv -----
`timescale 1ns / 1ps

module dpa_shifter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  dpa_pkg::shift_req_t             shift_i,
  input  logic [dpa_pkg::DataW-1:0]       rn_i,
  input  dpa_pkg::ctrl_t                  ctrl_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic [dpa_pkg::DataW-1:0]       operand_o,
  output logic                            shift_carry_o,
  output logic [dpa_pkg::DataW-1:0]       rn_o,
  output dpa_pkg::ctrl_t                  ctrl_o
);

  logic                        valid_q;
  logic [dpa_pkg::DataW-1:0]   operand_d, operand_q;
  logic                        carry_d, carry_q;
  logic [dpa_pkg::DataW-1:0]   rn_q;
  dpa_pkg::ctrl_t              ctrl_q;

  logic [dpa_pkg::DataW:0]     lsl_w;
  logic [dpa_pkg::DataW:0]     lsr_w;
  logic signed [dpa_pkg::DataW:0] asr_in;
  logic signed [dpa_pkg::DataW:0] asr_w;
  logic [2*dpa_pkg::DataW-1:0] ror_w;
  logic                        amt_zero;

  // One extra bit below or above the word catches the last bit shifted out
  assign lsl_w    = {1'b0, shift_i.data} << shift_i.amount;
  assign lsr_w    = {shift_i.data, 1'b0} >> shift_i.amount;
  assign asr_in   = {shift_i.data, 1'b0};
  assign asr_w    = asr_in >>> shift_i.amount;
  assign ror_w    = {shift_i.data, shift_i.data} >> shift_i.amount[4:0];
  assign amt_zero = (shift_i.amount == dpa_pkg::AmtZero);

  // Barrel shifter select
  always_comb begin
    operand_d = shift_i.data;
    carry_d   = ctrl_i.carry_in;
    case (shift_i.kind)
      dpa_pkg::SH_LSL: begin
        operand_d = lsl_w[dpa_pkg::DataW-1:0];
        carry_d   = amt_zero ? ctrl_i.carry_in : lsl_w[dpa_pkg::DataW];
      end
      dpa_pkg::SH_LSR: begin
        operand_d = lsr_w[dpa_pkg::DataW:1];
        carry_d   = amt_zero ? ctrl_i.carry_in : lsr_w[0];
      end
      dpa_pkg::SH_ASR: begin
        operand_d = asr_w[dpa_pkg::DataW:1];
        carry_d   = amt_zero ? ctrl_i.carry_in : asr_w[0];
      end
      dpa_pkg::SH_ROR: begin
        // carry out of a rotate is the new bit 31
        operand_d = ror_w[dpa_pkg::DataW-1:0];
        carry_d   = amt_zero ? ctrl_i.carry_in : ror_w[dpa_pkg::DataW-1];
      end
      dpa_pkg::SH_RRX: begin
        operand_d = {ctrl_i.carry_in, shift_i.data[dpa_pkg::DataW-1:1]};
        carry_d   = shift_i.data[0];
      end
      default: begin
        operand_d = shift_i.data;
        carry_d   = ctrl_i.carry_in;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  // Stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      operand_q <= operand_d;
      carry_q   <= carry_d;
      rn_q      <= rn_i;
      ctrl_q    <= ctrl_i;
    end
  end

  assign valid_o       = valid_q;
  assign operand_o     = operand_q;
  assign shift_carry_o = carry_q;
  assign rn_o          = rn_q;
  assign ctrl_o        = ctrl_q;

endmodule

// ----- rtl/core/dpa_alu.sv -----
`timescale 1ns / 1ps

module dpa_alu (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [dpa_pkg::DataW-1:0]       rn_i,
  input  logic [dpa_pkg::DataW-1:0]       operand_i,
  input  logic                            shift_carry_i,
  input  dpa_pkg::ctrl_t                  ctrl_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic [dpa_pkg::DataW-1:0]       result_o,
  output logic                            carry_o,
  output logic                            overflow_o,
  output dpa_pkg::ctrl_t                  ctrl_o
);

  logic                        valid_q;
  logic [dpa_pkg::DataW-1:0]   result_d, result_q;
  logic                        carry_d, carry_q;
  logic                        ovf_d, ovf_q;
  dpa_pkg::ctrl_t              ctrl_q;

  logic [dpa_pkg::DataW-1:0]   add_x, add_y;
  logic                        add_cin;
  logic [dpa_pkg::DataW:0]     sum;
  logic                        add_v;

  // Adder operand select: subtracts are x + ~y + carry
  always_comb begin
    add_x   = rn_i;
    add_y   = operand_i;
    add_cin = 1'b0;
    case (ctrl_i.opcode)
      dpa_pkg::OP_SUB, dpa_pkg::OP_CMP: begin
        add_y   = ~operand_i;
        add_cin = 1'b1;
      end
      dpa_pkg::OP_RSB: begin
        add_x   = operand_i;
        add_y   = ~rn_i;
        add_cin = 1'b1;
      end
      dpa_pkg::OP_ADC: begin
        add_cin = ctrl_i.carry_in;
      end
      dpa_pkg::OP_SBC: begin
        add_y   = ~operand_i;
        add_cin = ctrl_i.carry_in;
      end
      dpa_pkg::OP_RSC: begin
        add_x   = operand_i;
        add_y   = ~rn_i;
        add_cin = ctrl_i.carry_in;
      end
      default: begin
        add_x   = rn_i;
        add_y   = operand_i;
        add_cin = 1'b0;
      end
    endcase
  end

  assign sum   = {1'b0, add_x} + {1'b0, add_y} + {{dpa_pkg::DataW{1'b0}}, add_cin};
  assign add_v = (add_x[dpa_pkg::DataW-1] ^ sum[dpa_pkg::DataW-1]) &
                 (add_y[dpa_pkg::DataW-1] ^ sum[dpa_pkg::DataW-1]);

  // Result and C/V select
  always_comb begin
    result_d = sum[dpa_pkg::DataW-1:0];
    carry_d  = sum[dpa_pkg::DataW];
    ovf_d    = add_v;
    case (ctrl_i.opcode)
      dpa_pkg::OP_AND, dpa_pkg::OP_TST,
      dpa_pkg::OP_EOR, dpa_pkg::OP_TEQ,
      dpa_pkg::OP_ORR, dpa_pkg::OP_MOV,
      dpa_pkg::OP_BIC, dpa_pkg::OP_MVN: begin
        carry_d = shift_carry_i;
        ovf_d   = ctrl_i.overflow_in;
        case (ctrl_i.opcode)
          dpa_pkg::OP_AND, dpa_pkg::OP_TST: result_d = rn_i & operand_i;
          dpa_pkg::OP_EOR, dpa_pkg::OP_TEQ: result_d = rn_i ^ operand_i;
          dpa_pkg::OP_ORR:                  result_d = rn_i | operand_i;
          dpa_pkg::OP_MOV:                  result_d = operand_i;
          dpa_pkg::OP_BIC:                  result_d = rn_i & ~operand_i;
          default:                          result_d = ~operand_i;
        endcase
      end
      default: begin
        result_d = sum[dpa_pkg::DataW-1:0];
        carry_d  = sum[dpa_pkg::DataW];
        ovf_d    = add_v;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  // Stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      result_q <= result_d;
      carry_q  <= carry_d;
      ovf_q    <= ovf_d;
      ctrl_q   <= ctrl_i;
    end
  end

  assign valid_o    = valid_q;
  assign result_o   = result_q;
  assign carry_o    = carry_q;
  assign overflow_o = ovf_q;
  assign ctrl_o     = ctrl_q;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned HoldCycles    = 80;
  localparam int unsigned DrainCycles   = 12;
  localparam int unsigned MaxPrinted    = 30;

  // One instruction as seen on the input channel
  typedef struct packed {
    logic [31:0] instr;
    logic [31:0] rn;
    logic [31:0] rm;
    logic [31:0] rs;
    logic        cin;
    logic        vin;
    logic        user;
  } dp_item_t;

  // One execute result as seen on the output channel
  typedef struct packed {
    logic [31:0] result;
    logic [3:0]  rd;
    logic        write_result;
    logic        flags_update;
    logic        n;
    logic        z;
    logic        c;
    logic        v;
    logic        restore_psr;
    logic        illegal_mode;
    logic [2:0]  cycles;
  } dp_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] instr_i = '0;
  logic [31:0] rn_value_i = '0;
  logic [31:0] rm_value_i = '0;
  logic [31:0] rs_value_i = '0;
  logic        carry_in_i = 1'b0;
  logic        overflow_in_i = 1'b0;
  logic        user_mode_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] result_o;
  logic [3:0]  dest_reg_o;
  logic        write_result_o;
  logic        flags_update_o;
  logic        flag_n_o;
  logic        flag_z_o;
  logic        flag_c_o;
  logic        flag_v_o;
  logic        restore_psr_o;
  logic        illegal_mode_o;
  logic [2:0]  cycles_o;

  dp_result_t  pending_dp_results[$];
  int unsigned n_fail = 0;
  int unsigned n_instr = 0;
  int unsigned n_checked = 0;
  int unsigned n_in_stall = 0;
  int unsigned idle_cycles = 0;
  logic        tx_quiet = 1'b0;
  logic        rx_quiet = 1'b0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;

  arm_data_processing_alu u_dut (.*);

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Execute-stage prediction
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned r);
    logic [63:0] d;
    d = {x, x} >> r;
    return d[31:0];
  endfunction

  function automatic logic bit_at(input logic [31:0] x, input int unsigned i);
    logic [31:0] t;
    t = x >> i;
    return t[0];
  endfunction

  // Operand 2 and shifter carry out
  function automatic void barrel_shift(input logic [31:0] instr, input logic [31:0] rm,
                                       input logic [31:0] rs, input logic cin,
                                       output logic [31:0] val, output logic cout);
    int unsigned amt;
    logic signed [31:0] srm;
    srm = rm;
    if (instr[25]) begin
      // rotated 8-bit immediate
      amt = 32'(instr[11:8]) * 2;
      val = ror32({24'h0, instr[7:0]}, amt);
      cout = (amt == 0) ? cin : val[31];
    end else if (instr[4]) begin
      // shift by low byte of Rs
      amt = 32'(rs[7:0]);
      if (amt == 0) begin
        val = rm;
        cout = cin;
      end else begin
        case (instr[6:5])
          dpa_pkg::ShTypeLsl: begin
            val = (amt < 32) ? rm << amt : 32'h0;
            cout = (amt < 32) ? bit_at(rm, 32 - amt) : ((amt == 32) ? rm[0] : 1'b0);
          end
          dpa_pkg::ShTypeLsr: begin
            val = (amt < 32) ? rm >> amt : 32'h0;
            cout = (amt < 32) ? bit_at(rm, amt - 1) : ((amt == 32) ? rm[31] : 1'b0);
          end
          dpa_pkg::ShTypeAsr: begin
            val = (amt < 32) ? 32'(srm >>> amt) : {32{rm[31]}};
            cout = (amt < 32) ? bit_at(rm, amt - 1) : rm[31];
          end
          default: begin
            val = ror32(rm, amt % 32);
            cout = ((amt % 32) == 0) ? rm[31] : bit_at(rm, (amt % 32) - 1);
          end
        endcase
      end
    end else begin
      // shift by 5-bit immediate; zero means 32 for LSR/ASR and RRX for ROR
      amt = 32'(instr[11:7]);
      case (instr[6:5])
        dpa_pkg::ShTypeLsl: begin
          val = rm << amt;
          cout = (amt == 0) ? cin : bit_at(rm, 32 - amt);
        end
        dpa_pkg::ShTypeLsr: begin
          val = (amt == 0) ? 32'h0 : rm >> amt;
          cout = (amt == 0) ? rm[31] : bit_at(rm, amt - 1);
        end
        dpa_pkg::ShTypeAsr: begin
          val = (amt == 0) ? {32{rm[31]}} : 32'(srm >>> amt);
          cout = (amt == 0) ? rm[31] : bit_at(rm, amt - 1);
        end
        default: begin
          val = (amt == 0) ? {cin, rm[31:1]} : ror32(rm, amt);
          cout = (amt == 0) ? rm[0] : bit_at(rm, amt - 1);
        end
      endcase
    end
  endfunction

  function automatic logic [31:0] add_carry(input logic [31:0] a, input logic [31:0] b,
                                            input logic ci, output logic co, output logic vo);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b} + {32'h0, ci};
    co = sum[32];
    vo = (a[31] ^ sum[31]) & (b[31] ^ sum[31]);
    return sum[31:0];
  endfunction

  function automatic dp_result_t execute_dp(input dp_item_t it);
    dp_result_t        r;
    logic [31:0]       a, b, y;
    logic              c, v, s, is_test, reg_shift;
    logic [3:0]        rd;
    dpa_pkg::alu_op_e  op;
    barrel_shift(it.instr, it.rm, it.rs, it.cin, b, c);
    a = it.rn;
    v = it.vin;
    op = dpa_pkg::alu_op_e'(it.instr[24:21]);
    case (op)
      dpa_pkg::OP_AND, dpa_pkg::OP_TST: y = a & b;
      dpa_pkg::OP_EOR, dpa_pkg::OP_TEQ: y = a ^ b;
      dpa_pkg::OP_SUB, dpa_pkg::OP_CMP: y = add_carry(a, ~b, 1'b1, c, v);
      dpa_pkg::OP_RSB:                  y = add_carry(b, ~a, 1'b1, c, v);
      dpa_pkg::OP_ADD, dpa_pkg::OP_CMN: y = add_carry(a, b, 1'b0, c, v);
      dpa_pkg::OP_ADC:                  y = add_carry(a, b, it.cin, c, v);
      dpa_pkg::OP_SBC:                  y = add_carry(a, ~b, it.cin, c, v);
      dpa_pkg::OP_RSC:                  y = add_carry(b, ~a, it.cin, c, v);
      dpa_pkg::OP_ORR:                  y = a | b;
      dpa_pkg::OP_MOV:                  y = b;
      dpa_pkg::OP_BIC:                  y = a & ~b;
      default:                          y = ~b;
    endcase
    s = it.instr[20];
    rd = it.instr[15:12];
    is_test = (op == dpa_pkg::OP_TST) || (op == dpa_pkg::OP_TEQ) ||
              (op == dpa_pkg::OP_CMP) || (op == dpa_pkg::OP_CMN);
    reg_shift = !it.instr[25] && it.instr[4];
    r.result = y;
    r.rd = rd;
    r.restore_psr = s && (rd == dpa_pkg::PcReg) && !it.user;
    r.illegal_mode = s && (rd == dpa_pkg::PcReg) && it.user;
    r.flags_update = s && (rd != dpa_pkg::PcReg);
    r.write_result = !is_test && !r.illegal_mode;
    r.n = y[31];
    r.z = (y == 32'h0);
    r.c = c;
    r.v = v;
    r.cycles = 3'd1 + {2'b00, reg_shift} + ((rd == dpa_pkg::PcReg) ? 3'd2 : 3'd0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (n_fail < MaxPrinted) $display("MISMATCH: %s", msg);
    n_fail = n_fail + 1;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %h, want %h", n_checked, name, got, want));
  endtask

  // Input monitor and output scoreboard
  always @(posedge clk_i) begin : scoreboard
    dp_result_t got, want;
    dp_item_t   seen;
    if (rst_ni) begin
      if (in_valid_i && !in_ready_o) n_in_stall = n_in_stall + 1;
      if (out_valid_o && out_ready_i) begin
        if (pending_dp_results.size() == 0) begin
          report_mismatch($sformatf("result %h with no transaction pending", result_o));
        end else begin
          want = pending_dp_results.pop_front();
          got = '{result_o, dest_reg_o, write_result_o, flags_update_o, flag_n_o, flag_z_o,
                  flag_c_o, flag_v_o, restore_psr_o, illegal_mode_o, cycles_o};
          check_field("result", got.result, want.result);
          check_field("dest_reg", 32'(got.rd), 32'(want.rd));
          check_field("write_result", 32'(got.write_result), 32'(want.write_result));
          check_field("flags_update", 32'(got.flags_update), 32'(want.flags_update));
          check_field("flag_n", 32'(got.n), 32'(want.n));
          check_field("flag_z", 32'(got.z), 32'(want.z));
          check_field("flag_c", 32'(got.c), 32'(want.c));
          check_field("flag_v", 32'(got.v), 32'(want.v));
          check_field("restore_psr", 32'(got.restore_psr), 32'(want.restore_psr));
          check_field("illegal_mode", 32'(got.illegal_mode), 32'(want.illegal_mode));
          check_field("cycles", 32'(got.cycles), 32'(want.cycles));
        end
        n_checked = n_checked + 1;
      end
      if (in_valid_i && in_ready_o) begin
        seen = '{instr_i, rn_value_i, rm_value_i, rs_value_i, carry_in_i, overflow_in_i,
                 user_mode_i};
        pending_dp_results.push_back(execute_dp(seen));
        n_instr = n_instr + 1;
      end
    end
  end

  // Watchdog: any transaction on either channel restarts the count
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random ready, or a long hold-off on request
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_left <= HoldCycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rx_quiet || ($urandom_range(99) >= 12);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Drive one transaction; valid stays high into the next call unless it idles
  task automatic send_item(input dp_item_t it);
    while (!tx_quiet && ($urandom_range(99) < 12)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    instr_i <= it.instr;
    rn_value_i <= it.rn;
    rm_value_i <= it.rm;
    rs_value_i <= it.rs;
    carry_in_i <= it.cin;
    overflow_in_i <= it.vin;
    user_mode_i <= it.user;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic dp_item_t item(input logic [31:0] instr, input logic [31:0] rn,
                                    input logic [31:0] rm, input logic [31:0] rs,
                                    input logic cin, input logic vin, input logic user);
    return '{instr, rn, rm, rs, cin, vin, user};
  endfunction

  // Bits 31..26 are don't-care, so they are always random
  function automatic logic [31:0] dp_word(input logic imm_op, input dpa_pkg::alu_op_e op,
                                          input logic set_flags, input logic [3:0] rn,
                                          input logic [3:0] rd, input logic [11:0] op2);
    return {6'($urandom()), imm_op, op, set_flags, rn, rd, op2};
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Shift amounts weighted toward the boundaries
  function automatic logic [7:0] pick_amount();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd31;
      3:       return 8'd32;
      4:       return 8'd33;
      5:       return 8'(32 * $urandom_range(7));
      6:       return 8'($urandom_range(31));
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic dp_item_t rand_item();
    dp_item_t    it;
    logic [11:0] op2;
    logic [7:0]  amt;
    logic [1:0]  sh;
    logic [3:0]  rd;
    logic        imm_op;
    sh = 2'($urandom());
    amt = pick_amount();
    case ($urandom_range(9))
      0, 1, 2: begin
        imm_op = 1'b1;
        op2 = {4'($urandom()), 8'($urandom())};
      end
      3, 4, 5: begin
        imm_op = 1'b0;
        op2 = {amt[4:0], sh, 1'b0, 4'($urandom())};
      end
      6, 7, 8: begin
        imm_op = 1'b0;
        op2 = {4'($urandom()), 1'($urandom()), sh, 1'b1, 4'($urandom())};
      end
      default: begin
        imm_op = 1'($urandom());
        op2 = 12'($urandom());
      end
    endcase
    rd = ($urandom_range(7) == 0) ? dpa_pkg::PcReg : 4'($urandom());
    it.instr = dp_word(imm_op, dpa_pkg::alu_op_e'(4'($urandom())), 1'($urandom()),
                       4'($urandom()), rd, op2);
    it.rn = pick_word();
    it.rm = pick_word();
    it.rs = {24'($urandom()), amt};
    it.cin = 1'($urandom());
    it.vin = 1'($urandom());
    it.user = 1'($urandom());
    return it;
  endfunction

  // Opcodes, PSR handling and shifter corners
  task automatic test_directed();
    // all 16 opcodes; odd ones set S, MVN targets the PC (restore)
    for (int k = 0; k < 16; k++)
      send_item(item(dp_word(1'b1, dpa_pkg::alu_op_e'(k[3:0]), k[0], 4'(k), 4'(k), 12'h0FF),
                     k[0] ? 32'hFFFF_FFFF : 32'h0, $urandom(), $urandom(), k[1], k[2],
                     1'b0));
    // S with Rd = PC in user mode
    send_item(item(dp_word(1'b0, dpa_pkg::OP_MOV, 1'b1, 4'h0, dpa_pkg::PcReg,
                           {5'd3, dpa_pkg::ShTypeLsl, 1'b0, 4'h1}),
                   32'h0, 32'h1234_5678, 32'h0, 1'b0, 1'b0, 1'b1));
    // immediate shift by zero: pass, shift by 32, shift by 32, RRX
    send_item(item(dp_word(1'b0, dpa_pkg::OP_MOV, 1'b1, 4'h0, 4'h1,
                           {5'd0, dpa_pkg::ShTypeLsl, 1'b0, 4'h2}),
                   32'h0, 32'h8000_0001, 32'h0, 1'b1, 1'b0, 1'b0));
    send_item(item(dp_word(1'b0, dpa_pkg::OP_MOV, 1'b1, 4'h0, 4'h1,
                           {5'd0, dpa_pkg::ShTypeLsr, 1'b0, 4'h2}),
                   32'h0, 32'h8000_0001, 32'h0, 1'b0, 1'b1, 1'b0));
    send_item(item(dp_word(1'b0, dpa_pkg::OP_MOV, 1'b1, 4'h0, 4'h1,
                           {5'd0, dpa_pkg::ShTypeAsr, 1'b0, 4'h2}),
                   32'h0, 32'h8000_0001, 32'h0, 1'b0, 1'b0, 1'b0));
    send_item(item(dp_word(1'b0, dpa_pkg::OP_MOV, 1'b1, 4'h0, 4'h1,
                           {5'd0, dpa_pkg::ShTypeRor, 1'b0, 4'h2}),
                   32'h0, 32'h8000_0001, 32'h0, 1'b1, 1'b0, 1'b0));
    // register shift by zero (ROR type) keeps Rm and carry
    send_item(item(dp_word(1'b0, dpa_pkg::OP_MOV, 1'b1, 4'h0, 4'h1,
                           {4'h3, 1'b0, dpa_pkg::ShTypeRor, 1'b1, 4'h2}),
                   32'h0, 32'hDEAD_BEEF, 32'h0000_0100, 1'b1, 1'b0, 1'b0));
    // register shifts of 32 and beyond
    send_item(item(dp_word(1'b0, dpa_pkg::OP_MOV, 1'b1, 4'h0, 4'h1,
                           {4'h3, 1'b0, dpa_pkg::ShTypeLsl, 1'b1, 4'h2}),
                   32'h0, 32'h8000_0001, 32'hFFFF_FF20, 1'b0, 1'b0, 1'b0));
    send_item(item(dp_word(1'b0, dpa_pkg::OP_MOV, 1'b1, 4'h0, 4'h1,
                           {4'h3, 1'b0, dpa_pkg::ShTypeLsr, 1'b1, 4'h2}),
                   32'h0, 32'h8000_0001, 32'h0000_0028, 1'b1, 1'b0, 1'b0));
    send_item(item(dp_word(1'b0, dpa_pkg::OP_MOV, 1'b1, 4'h0, 4'h1,
                           {4'h3, 1'b0, dpa_pkg::ShTypeAsr, 1'b1, 4'h2}),
                   32'h0, 32'h8000_0001, 32'h0000_00C8, 1'b0, 1'b0, 1'b0));
    send_item(item(dp_word(1'b0, dpa_pkg::OP_MOV, 1'b1, 4'h0, 4'h1,
                           {4'h3, 1'b0, dpa_pkg::ShTypeRor, 1'b1, 4'h2}),
                   32'h0, 32'h8000_0001, 32'h0000_0040, 1'b0, 1'b0, 1'b0));
  endtask

  task automatic test_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_item(rand_item());
  endtask

  // Back to back on both sides
  task automatic test_full_rate(input int unsigned count);
    tx_quiet = 1'b1;
    rx_quiet <= 1'b1;
    for (int unsigned i = 0; i < count; i++) send_item(rand_item());
    tx_quiet = 1'b0;
    rx_quiet <= 1'b0;
  endtask

  // Long result-side hold-off while the sender keeps pushing
  task automatic test_backpressure(input int unsigned count);
    hold_req <= hold_req + 1;
    tx_quiet = 1'b1;
    for (int unsigned i = 0; i < count; i++) send_item(rand_item());
    tx_quiet = 1'b0;
  endtask

  // Sender goes quiet until the pipeline is empty, then resumes
  task automatic test_drain_pause(input int unsigned count);
    test_random(count / 2);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_dp_results.size() != 0) @(posedge clk_i);
    test_random(count - count / 2);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(300);
    test_full_rate(100);
    test_backpressure(40);
    test_random(200);
    test_drain_pause(40);
    test_random(100);

    // wait for the pipeline to empty, then DrainCycles more for stray results
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_dp_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d instructions (all opcodes, immediate and register shifts, PSR cases)",
             n_instr);
    $display("checked %0d results, %0d input stall cycles, %0d mismatches",
             n_checked, n_in_stall, n_fail);
    if (n_fail == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
